// ===== sv/bsmd_pkg.sv =====
// Shared types, constants and the page layout table of the bank-switched memory map decoder.
// Used by bsmd_ctrl, bsmd_datapath and the top level; depends on nothing else.
package bsmd_pkg;

    // Storage geometry
    localparam int unsigned RAM_PAGES        = 16;
    localparam int unsigned PAGE_BYTES       = 4096;
    localparam int unsigned COLOUR_RAM_BYTES = 1024;
    localparam int unsigned MAIN_AW          = $clog2(RAM_PAGES * PAGE_BYTES);
    localparam int unsigned COL_AW           = $clog2(COLOUR_RAM_BYTES);

    // Bus field widths
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned TARGET_W = 4;
    localparam int unsigned OFFSET_W = 13;
    localparam int unsigned MASK_W   = 16;

    // Stream packing
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = 48;
    localparam int unsigned M_TUSER_W = 5;

    // Reset contents and special addresses
    localparam logic [DATA_W-1:0] RESET_BYTE0     = 8'h2f;
    localparam logic [DATA_W-1:0] RESET_BYTE1     = 8'h37;
    localparam logic [2:0]        RESET_LAYOUT    = 3'd7;
    localparam logic [ADDR_W-1:0] PORT_ADDR       = 16'h0001;
    localparam int unsigned       PORT_TAPE_BIT   = 4;
    localparam logic [5:0]        IO_WINDOW_BASE  = 6'b111000;

    // Access kind carried on the slave tuser
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // What a 4K page maps to
    typedef enum logic [2:0] {
        PG_RAM    = 3'd0,
        PG_BASIC  = 3'd1,
        PG_KERNAL = 3'd2,
        PG_CHAR   = 3'd3,
        PG_IO     = 3'd4
    } t_kind;

    // Result target codes
    typedef enum logic [TARGET_W-1:0] {
        T_RAM    = 4'd0,
        T_BASIC  = 4'd1,
        T_KERNAL = 4'd2,
        T_CHAR   = 4'd3,
        T_VIDEO  = 4'd4,
        T_SOUND  = 4'd5,
        T_COLOUR = 4'd6,
        T_TIMER1 = 4'd7,
        T_TIMER2 = 4'd8
    } t_target;

    // Source of the read byte in the result
    typedef enum logic [1:0] {
        SRC_NONE   = 2'd0,
        SRC_PORT   = 2'd1,
        SRC_MAIN   = 2'd2,
        SRC_COLOUR = 2'd3
    } t_src;

    // Controller commands and datapath status
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_status;

    // Banked pages A, B, D, E/F for each of the eight layouts
    localparam t_kind LAYOUT_HI [8][4] = '{
        '{PG_RAM,   PG_RAM,   PG_RAM,  PG_RAM},
        '{PG_RAM,   PG_RAM,   PG_CHAR, PG_RAM},
        '{PG_RAM,   PG_RAM,   PG_CHAR, PG_KERNAL},
        '{PG_BASIC, PG_BASIC, PG_CHAR, PG_KERNAL},
        '{PG_RAM,   PG_RAM,   PG_RAM,  PG_RAM},
        '{PG_RAM,   PG_RAM,   PG_IO,   PG_RAM},
        '{PG_RAM,   PG_RAM,   PG_IO,   PG_KERNAL},
        '{PG_BASIC, PG_BASIC, PG_IO,   PG_KERNAL}
    };

    // Map a page number through the selected layout
    function automatic t_kind page_kind(input logic [2:0] layout, input logic [3:0] page);
        t_kind k;
        unique case (page)
            4'hA:        k = LAYOUT_HI[layout][0];
            4'hB:        k = LAYOUT_HI[layout][1];
            4'hD:        k = LAYOUT_HI[layout][2];
            4'hE, 4'hF:  k = LAYOUT_HI[layout][3];
            default:     k = PG_RAM;
        endcase
        return k;
    endfunction

endpackage

// ===== sv/bank_switched_memory_map_decoder.sv =====
// Bank-switched memory map decoder: one CPU bus access in, one decoded result out.
// Path to a result: decode and RAM read into the capture registers at accept, then the
// result register, whose load waits while it is held by a stalled master side.
// A new access is accepted only after the previous one is loaded into the result register.
// Reset (synchronous, active low) starts a clearing pass of all 65536 main RAM bytes, one byte
// a cycle, during which no access is accepted; colour RAM is not cleared.
module bank_switched_memory_map_decoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // address[15:0], write_data[23:16], cass_sense[24], zero fill
    input  logic [bsmd_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // command[0]
    input  logic [bsmd_pkg::S_TUSER_W-1:0]     i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // target_offset[12:0], read_data[20:13], pass_data[28:21], touched_pages[44:29], zero fill
    output logic [bsmd_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // target[3:0], data_valid[4]
    output logic [bsmd_pkg::M_TUSER_W-1:0]     o_m_tuser
);
    import bsmd_pkg::*;

    t_ctrl_cmd           cmd;
    t_dp_status          status;
    logic [TARGET_W-1:0] target;
    logic [OFFSET_W-1:0] target_offset;
    logic [DATA_W-1:0]   read_data;
    logic                data_valid;
    logic [DATA_W-1:0]   pass_data;
    logic [MASK_W-1:0]   touched_pages;

    bsmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bsmd_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_command       (i_s_tuser[0]),
        .i_address       (i_s_tdata[15:0]),
        .i_write_data    (i_s_tdata[23:16]),
        .i_cass_sense    (i_s_tdata[24]),
        .o_target        (target),
        .o_target_offset (target_offset),
        .o_read_data     (read_data),
        .o_data_valid    (data_valid),
        .o_pass_data     (pass_data),
        .o_touched_pages (touched_pages)
    );

    // Pack the result
    assign o_m_tdata = {3'b000, touched_pages, pass_data, read_data, target_offset};
    assign o_m_tuser = {data_valid, target};

endmodule

// ===== sv/bsmd_ctrl.sv =====
// Controller of the bank-switched memory map decoder: clearing pass, accept and result load.
// Depends on bsmd_pkg for the command and status structs.
module bsmd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    input  bsmd_pkg::t_dp_status  i_status,
    output bsmd_pkg::t_ctrl_cmd   o_cmd
);
    import bsmd_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOAD  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept, load;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = o_s_tready && i_s_tvalid;
    // Load the result register when it is empty or being emptied
    assign load       = (r_state == S_LOAD) && (!r_out_valid || i_m_tready);

    assign o_cmd.clear_en = (r_state == S_CLEAR);
    assign o_cmd.accept   = accept;
    assign o_cmd.load     = load;
    assign o_m_tvalid     = r_out_valid;

    // Advance the state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_status.clear_last) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_LOAD;
            S_LOAD:  if (load) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Hold the result valid until the transaction completes
    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/bsmd_datapath.sv =====
// Datapath of the bank-switched memory map decoder: decode, main and colour RAM, port state.
// Depends on bsmd_pkg for the layout table, codes and command structs.
module bsmd_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bsmd_pkg::t_ctrl_cmd                 i_cmd,
    output bsmd_pkg::t_dp_status                o_status,
    input  logic                                i_command,
    input  logic [bsmd_pkg::ADDR_W-1:0]         i_address,
    input  logic [bsmd_pkg::DATA_W-1:0]         i_write_data,
    input  logic                                i_cass_sense,
    output logic [bsmd_pkg::TARGET_W-1:0]       o_target,
    output logic [bsmd_pkg::OFFSET_W-1:0]       o_target_offset,
    output logic [bsmd_pkg::DATA_W-1:0]         o_read_data,
    output logic                                o_data_valid,
    output logic [bsmd_pkg::DATA_W-1:0]         o_pass_data,
    output logic [bsmd_pkg::MASK_W-1:0]         o_touched_pages
);
    import bsmd_pkg::*;

    // Memories
    logic [DATA_W-1:0] main_mem   [RAM_PAGES*PAGE_BYTES];
    logic [DATA_W-1:0] colour_mem [COLOUR_RAM_BYTES];

    // Control state
    logic [MAIN_AW-1:0] r_clr_cnt;
    logic [2:0]         r_layout;
    logic [DATA_W-1:0]  r_port;
    logic [MASK_W-1:0]  r_mask;

    // Registered access between accept and load
    t_target            r_q_target;
    logic [OFFSET_W-1:0] r_q_offset;
    logic               r_q_valid;
    logic [DATA_W-1:0]  r_q_pass;
    t_src               r_q_src;
    logic [DATA_W-1:0]  r_q_port;
    logic [DATA_W-1:0]  r_main_q;
    logic [DATA_W-1:0]  r_col_q;

    // Result register
    logic [TARGET_W-1:0] r_target;
    logic [OFFSET_W-1:0] r_offset;
    logic [DATA_W-1:0]   r_rdata;
    logic                r_valid;
    logic [DATA_W-1:0]   r_pass;
    logic [MASK_W-1:0]   r_touched;

    // Decode
    logic [3:0]          page;
    logic [3:0]          sel;
    t_kind               kind;
    logic                is_wr;
    logic                is_port;
    t_target             d_target;
    logic [OFFSET_W-1:0] d_offset;
    logic                d_valid;
    logic                d_pass_en;
    t_src                d_src;
    logic                d_main_wr;
    logic                d_window;
    logic                d_colour;
    logic [MAIN_AW-1:0]  main_addr;
    logic [DATA_W-1:0]   main_wdata;
    logic                main_we;
    logic                main_re;
    logic [DATA_W-1:0]   clear_byte;
    logic [DATA_W-1:0]   port_rd;

    assign page    = i_address[15:12];
    assign sel     = i_address[11:8];
    assign kind    = page_kind(r_layout, page);
    assign is_wr   = (i_command == CMD_WRITE);
    assign is_port = (i_address == PORT_ADDR);

    // Port byte as read: tape sense replaces bit 4
    always_comb begin
        port_rd                = r_port;
        port_rd[PORT_TAPE_BIT] = i_cass_sense;
    end

    // Decode the access through the current layout
    always_comb begin
        d_target  = T_RAM;
        d_offset  = '0;
        d_valid   = 1'b0;
        d_pass_en = 1'b0;
        d_src     = SRC_NONE;
        d_main_wr = 1'b0;
        d_window  = 1'b0;
        d_colour  = 1'b0;
        if (!is_wr && is_port) begin
            d_valid = 1'b1;
            d_src   = SRC_PORT;
        end else if (kind == PG_IO) begin
            priority if (sel < 4'd4) begin
                d_target  = T_VIDEO;
                d_offset  = {3'b000, i_address[9:0]};
                d_pass_en = is_wr;
            end else if (sel < 4'd8) begin
                d_target  = T_SOUND;
                d_offset  = {3'b000, i_address[9:0]};
                d_pass_en = is_wr;
            end else if (sel < 4'd12) begin
                d_target = T_COLOUR;
                d_offset = {3'b000, i_address[9:0]};
                d_colour = 1'b1;
                d_valid  = !is_wr;
                d_src    = is_wr ? SRC_NONE : SRC_COLOUR;
            end else if (sel == 4'd12) begin
                d_target  = T_TIMER1;
                d_offset  = {9'd0, i_address[3:0]};
                d_pass_en = is_wr;
            end else if (sel == 4'd13) begin
                d_target  = T_TIMER2;
                d_offset  = {9'd0, i_address[3:0]};
                d_pass_en = is_wr;
            end else begin
                // RAM window under the I/O page
                d_window  = 1'b1;
                d_main_wr = is_wr;
                d_valid   = !is_wr;
                d_src     = is_wr ? SRC_NONE : SRC_MAIN;
            end
        end else if (is_wr) begin
            // Writes under ROM land in RAM
            d_main_wr = 1'b1;
        end else begin
            unique case (kind)
                PG_BASIC: begin
                    d_target = T_BASIC;
                    d_offset = {page[0], i_address[11:0]};
                end
                PG_KERNAL: begin
                    d_target = T_KERNAL;
                    d_offset = {page[0], i_address[11:0]};
                end
                PG_CHAR: begin
                    d_target = T_CHAR;
                    d_offset = {1'b0, i_address[11:0]};
                end
                default: begin
                    d_valid = 1'b1;
                    d_src   = SRC_MAIN;
                end
            endcase
        end
    end

    // Main RAM port: clearing pass or the accepted access
    always_comb begin
        unique case (r_clr_cnt)
            MAIN_AW'(0): clear_byte = RESET_BYTE0;
            MAIN_AW'(1): clear_byte = RESET_BYTE1;
            default:     clear_byte = '0;
        endcase
    end

    assign main_addr  = i_cmd.clear_en ? r_clr_cnt :
                        d_window ? {IO_WINDOW_BASE, i_address[9:0]} : i_address;
    assign main_wdata = i_cmd.clear_en ? clear_byte : i_write_data;
    assign main_we    = i_cmd.clear_en || (i_cmd.accept && d_main_wr);
    assign main_re    = i_cmd.accept && !is_wr && (d_src == SRC_MAIN);

    assign o_status.clear_last = i_cmd.clear_en && (r_clr_cnt == '1);

    always_ff @(posedge i_clk) begin
        if (main_we) begin
            main_mem[main_addr] <= main_wdata;
        end
        if (main_re) begin
            r_main_q <= main_mem[main_addr];
        end
    end

    // Colour RAM
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && d_colour) begin
            if (is_wr) begin
                colour_mem[i_address[COL_AW-1:0]] <= i_write_data;
            end else begin
                r_col_q <= colour_mem[i_address[COL_AW-1:0]];
            end
        end
    end

    // Clear counter, port byte, layout select and touched mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_layout  <= RESET_LAYOUT;
            r_port    <= RESET_BYTE1;
            r_mask    <= '0;
        end else begin
            if (i_cmd.clear_en) begin
                r_clr_cnt <= r_clr_cnt + MAIN_AW'(1);
            end
            if (i_cmd.accept && is_wr && is_port) begin
                r_port <= i_write_data;
                if (i_write_data != r_port) begin
                    r_layout <= i_write_data[2:0];
                end
            end
            if (i_cmd.accept && is_wr && (kind != PG_IO)) begin
                r_mask <= r_mask | (MASK_W'(1) << page);
            end
        end
    end

    // Capture the decoded access
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_q_target <= d_target;
            r_q_offset <= d_offset;
            r_q_valid  <= d_valid;
            r_q_pass   <= d_pass_en ? i_write_data : '0;
            r_q_src    <= d_src;
            r_q_port   <= port_rd;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target  <= r_q_target;
            r_offset  <= r_q_offset;
            r_valid   <= r_q_valid;
            r_pass    <= r_q_pass;
            r_touched <= r_mask;
            unique case (r_q_src)
                SRC_PORT:   r_rdata <= r_q_port;
                SRC_MAIN:   r_rdata <= r_main_q;
                SRC_COLOUR: r_rdata <= r_col_q;
                default:    r_rdata <= '0;
            endcase
        end
    end

    assign o_target        = r_target;
    assign o_target_offset = r_offset;
    assign o_read_data     = r_rdata;
    assign o_data_valid    = r_valid;
    assign o_pass_data     = r_pass;
    assign o_touched_pages = r_touched;

endmodule
